[design/dotf_pkg.sv]
// ============================================================================
// DHCP option TLV finder - shared package
// Item and result types, scan phase codes and field widths.
// ============================================================================
package dotf_pkg;

    // Default size of the option area; the top level takes it as a parameter.
    localparam int unsigned MAX_AREA_BYTES_DEF = 2048;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned AREA_W = 12;
    localparam int unsigned OUT_W  = 11;

    localparam logic [OUT_W-1:0]  OUT_MAX = 11'd2047;
    localparam logic [BYTE_W-1:0] TAG_PAD = 8'h00;
    localparam logic [BYTE_W-1:0] TAG_END = 8'hFF;

    // One byte of the option area together with its side information.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] wanted_code;
        logic [BYTE_W-1:0] expected_length;
        logic [AREA_W-1:0] area_length;
        logic              end_of_area;
    } in_item_t;

    // The summary reported after the last byte of an area.
    typedef struct packed {
        logic             found;
        logic [OUT_W-1:0] value_offset;
        logic [OUT_W-1:0] value_length;
        logic             length_mismatch;
    } result_t;

    // Where the parser stands within the current record.
    typedef enum logic [3:0] {
        PHASE_TAG    = 4'b0001,
        PHASE_LENGTH = 4'b0010,
        PHASE_SKIP   = 4'b0100,
        PHASE_DONE   = 4'b1000
    } phase_t;

endpackage

[design/dotf_byte_if.sv]
// ============================================================================
// DHCP option TLV finder - byte channel
// Valid/ready channel that carries one option-area byte and its context.
// ============================================================================
interface dotf_byte_if;

    logic                       valid;
    logic                       ready;
    logic [dotf_pkg::BYTE_W-1:0] data_byte;
    logic [dotf_pkg::BYTE_W-1:0] wanted_code;
    logic [dotf_pkg::BYTE_W-1:0] expected_length;
    logic [dotf_pkg::AREA_W-1:0] area_length;
    logic                       end_of_area;

    modport source (
        output valid, data_byte, wanted_code, expected_length, area_length, end_of_area,
        input  ready
    );

    modport sink (
        input  valid, data_byte, wanted_code, expected_length, area_length, end_of_area,
        output ready
    );

endinterface

[design/dotf_result_if.sv]
// ============================================================================
// DHCP option TLV finder - result channel
// Valid/ready channel that carries the search summary of one option area.
// ============================================================================
interface dotf_result_if;

    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [dotf_pkg::OUT_W-1:0] value_offset;
    logic [dotf_pkg::OUT_W-1:0] value_length;
    logic                       length_mismatch;

    modport source (
        output valid, found, value_offset, value_length, length_mismatch,
        input  ready
    );

    modport sink (
        input  valid, found, value_offset, value_length, length_mismatch,
        output ready
    );

endinterface

[design/dotf_scan.sv]
// ============================================================================
// DHCP option TLV finder - record scanner
// Holds the parse state and updates it for one byte per cycle while fire
// is high; forms the summary that belongs to the area's last byte.
// ============================================================================
module dotf_scan #(
    parameter int unsigned MAX_AREA_BYTES = dotf_pkg::MAX_AREA_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dotf_pkg::in_item_t item,
    output dotf_pkg::result_t  res
);

    localparam int unsigned PW = $clog2(MAX_AREA_BYTES + 1);
    // Compare width: covers the position counter and the area length plus a carry.
    localparam int unsigned CW = ((PW > dotf_pkg::AREA_W) ? PW : dotf_pkg::AREA_W) + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_AREA_BYTES);
    localparam logic [PW-1:0] MAX_P = PW'(MAX_AREA_BYTES);

    logic [PW-1:0]              pos_reg,     pos_next;
    dotf_pkg::phase_t           phase_reg,   phase_next;
    logic [dotf_pkg::BYTE_W-1:0] skip_reg,   skip_next;
    logic                       pending_reg, pending_next;
    logic [PW-1:0]              start_reg,   start_next;
    logic [dotf_pkg::OUT_W-1:0] total_reg,   total_next;
    logic                       seen_reg,    seen_next;

    logic [CW-1:0]              area_c;
    logic [CW-1:0]              pos_c;
    logic [CW-1:0]              pos_plus1;
    logic [CW-1:0]              end_sum;
    logic [CW-1:0]              clip_w;
    logic [dotf_pkg::BYTE_W-1:0] clip_len;
    logic [dotf_pkg::OUT_W:0]   total_sum;
    logic                       in_area;
    logic                       tag_ok;
    logic [CW-1:0]              off_c;
    logic                       mismatch;

    always_comb
    begin
        // Areas longer than the supported size are treated as full size.
        area_c    = (CW'(item.area_length) > MAX_C) ? MAX_C : CW'(item.area_length);
        pos_c     = CW'(pos_reg);
        pos_plus1 = pos_c + CW'(1);
        in_area   = pos_c < area_c;
        tag_ok    = pos_plus1 < area_c;

        // A matched length is cut to the bytes that remain in the area.
        end_sum  = pos_c + CW'(item.data_byte);
        clip_w   = (end_sum < area_c) ? CW'(item.data_byte) : (area_c - pos_plus1);
        clip_len = clip_w[dotf_pkg::BYTE_W-1:0];
        total_sum = {1'b0, total_reg} + (dotf_pkg::OUT_W + 1)'(clip_len);

        pos_next     = pos_reg;
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        pending_next = pending_reg;
        start_next   = start_reg;
        total_next   = total_reg;
        seen_next    = seen_reg;

        if (in_area)
        begin
            if (pending_reg)
            begin
                start_next   = pos_plus1[PW-1:0];
                total_next   = total_sum[dotf_pkg::OUT_W] ? dotf_pkg::OUT_MAX
                                                          : total_sum[dotf_pkg::OUT_W-1:0];
                seen_next    = 1'b1;
                pending_next = 1'b0;
            end
            case (phase_reg)
                dotf_pkg::PHASE_TAG:
                begin
                    if (tag_ok)
                    begin
                        if (item.data_byte == item.wanted_code)
                        begin
                            pending_next = 1'b1;
                        end
                        if (item.data_byte == dotf_pkg::TAG_END)
                        begin
                            phase_next = dotf_pkg::PHASE_DONE;
                        end
                        else if (item.data_byte != dotf_pkg::TAG_PAD)
                        begin
                            phase_next = dotf_pkg::PHASE_LENGTH;
                        end
                    end
                    else
                    begin
                        phase_next = dotf_pkg::PHASE_DONE;
                    end
                end
                dotf_pkg::PHASE_LENGTH:
                begin
                    skip_next  = item.data_byte;
                    phase_next = (item.data_byte != '0) ? dotf_pkg::PHASE_SKIP
                                                        : dotf_pkg::PHASE_TAG;
                end
                dotf_pkg::PHASE_SKIP:
                begin
                    if (skip_reg > 8'd1)
                    begin
                        skip_next = skip_reg - 8'd1;
                    end
                    else
                    begin
                        skip_next  = '0;
                        phase_next = dotf_pkg::PHASE_TAG;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (pos_reg < MAX_P)
        begin
            pos_next = pos_reg + PW'(1);
        end

        // The summary uses the state as updated by the last byte itself.
        mismatch = (item.expected_length != '0)
                && (total_next != dotf_pkg::OUT_W'(item.expected_length));
        off_c    = seen_next ? CW'(start_next) : '0;
        res.found           = seen_next && !mismatch;
        res.value_offset    = (off_c > CW'(dotf_pkg::OUT_MAX)) ? dotf_pkg::OUT_MAX
                                                               : off_c[dotf_pkg::OUT_W-1:0];
        res.value_length    = total_next;
        res.length_mismatch = mismatch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            phase_reg   <= dotf_pkg::PHASE_TAG;
            skip_reg    <= '0;
            pending_reg <= 1'b0;
            start_reg   <= '0;
            total_reg   <= '0;
            seen_reg    <= 1'b0;
        end
        else if (fire)
        begin
            if (item.end_of_area)
            begin
                pos_reg     <= '0;
                phase_reg   <= dotf_pkg::PHASE_TAG;
                skip_reg    <= '0;
                pending_reg <= 1'b0;
                start_reg   <= '0;
                total_reg   <= '0;
                seen_reg    <= 1'b0;
            end
            else
            begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                skip_reg    <= skip_next;
                pending_reg <= pending_next;
                start_reg   <= start_next;
                total_reg   <= total_next;
                seen_reg    <= seen_next;
            end
        end
    end

endmodule

[design/dhcp_option_tlv_finder.sv]
// ============================================================================
// DHCP option TLV finder - top level
// Scans a DHCP option area byte by byte and reports where the wanted option's
// value lies and how long it is.
// ============================================================================
// The bytes channel takes one byte of the option area per item, in order,
// with the wanted tag, the expected total length and the area length held
// constant across the area. The item flagged end_of_area closes the area.
// The result channel then carries one item: found, value offset, summed
// value length and the length-mismatch flag. Bytes that are not last cause
// no result item.
// Every accepted byte goes into an input register; the scanner updates its
// state from that register as the byte leaves it, so one byte is taken per
// clock unless a stalled result holds bytes ready low. A result item is
// loaded into the result register as its last byte leaves the input register.
// The result register lets bytes of the next area flow in while a result
// waits; when the receiver stalls and a second last byte reaches the input
// register, bytes ready drops until the waiting result is taken.
// After reset both registers are empty and the scanner waits for a tag at
// offset zero; the scanner also returns to that state after every area.
// ============================================================================
module dhcp_option_tlv_finder #(
    parameter int unsigned MAX_AREA_BYTES = dotf_pkg::MAX_AREA_BYTES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dotf_byte_if.sink     bytes,
    dotf_result_if.source result
);

    logic               stage_valid_reg, stage_valid_next;
    dotf_pkg::in_item_t stage_item_reg;
    logic               out_valid_reg,   out_valid_next;
    dotf_pkg::result_t  out_item_reg;
    dotf_pkg::result_t  scan_res;
    logic               stage_fire;
    logic               stage_free;
    logic               out_load;
    logic               bytes_take;

    // The staged byte moves on unless it is a last byte that finds the
    // result register still occupied by a result nobody has taken.
    assign stage_fire = stage_valid_reg
                     && (!stage_item_reg.end_of_area || !out_valid_reg || result.ready);
    assign stage_free = !stage_valid_reg || stage_fire;
    assign out_load   = stage_fire && stage_item_reg.end_of_area;
    assign bytes_take = bytes.valid && stage_free;

    assign bytes.ready = stage_free;

    assign stage_valid_next = bytes_take || (stage_valid_reg && !stage_fire);
    assign out_valid_next   = out_load || (out_valid_reg && !result.ready);

    dotf_scan #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (stage_fire),
        .item  (stage_item_reg),
        .res   (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (bytes_take)
        begin
            stage_item_reg.data_byte       <= bytes.data_byte;
            stage_item_reg.wanted_code     <= bytes.wanted_code;
            stage_item_reg.expected_length <= bytes.expected_length;
            stage_item_reg.area_length     <= bytes.area_length;
            stage_item_reg.end_of_area     <= bytes.end_of_area;
        end
        if (out_load)
        begin
            out_item_reg <= scan_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.found           = out_item_reg.found;
    assign result.value_offset    = out_item_reg.value_offset;
    assign result.value_length    = out_item_reg.value_length;
    assign result.length_mismatch = out_item_reg.length_mismatch;

`ifndef SYNTHESIS
    // A last byte leaving the input register always yields a result next cycle.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result.valid)
        else $error("last byte did not produce a result");

    // Back-pressure on bytes comes only from a last byte held behind a stalled result.
    a_ready_only_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !bytes.ready |-> (stage_valid_reg && stage_item_reg.end_of_area
                          && out_valid_reg && !result.ready))
        else $error("bytes channel stalled without cause");

    // A found option never carries a failed length check.
    a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(result.found && result.length_mismatch))
        else $error("found reported together with a length mismatch");
`endif

endmodule
